@@ rtl/mcv_pkg.sv @@
package mcv_pkg;

   // coordinate width default, each vertex coordinate is signed Q8.8
   localparam int MCV_COORD_WIDTH = 16;

   // running sum and result widths
   localparam int SUM_W = 64;
   localparam int ACC_W = 63;
   localparam int MAG_W = 62;
   localparam int VOL_W = 60;

   localparam logic signed [SUM_W-1:0] SUM_POS_LIMIT = {2'b00, {(SUM_W-2){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = {2'b11, {(SUM_W-3){1'b0}}, 1'b1};

   // radix-4 divide by six: two quotient bits per step
   localparam int DIV_STEPS = MAG_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int REM_W     = 3;
   localparam logic [REM_W+1:0] DIV_SIX    = 5'd6;
   localparam logic [REM_W+1:0] DIV_TWELVE = 5'd12;

   typedef struct packed {
      logic take;
      logic div_start;
      logic div_step;
      logic rsp_load;
   } mcv_cmd_type;

   typedef struct packed {
      logic sum_ready;
   } mcv_status_type;

endpackage

@@ rtl/mcv_datapath.sv @@
module mcv_datapath #(
   parameter int COORD_WIDTH = mcv_pkg::MCV_COORD_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  mcv_pkg::mcv_cmd_type         cmd,
   output mcv_pkg::mcv_status_type      status,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   input  logic                         req_last_triangle,
   input  logic                         csr_write_enable,
   input  logic [mcv_pkg::VOL_W-1:0]    csr_write_data,
   output logic [mcv_pkg::VOL_W-1:0]    rsp_volume,
   output logic                         rsp_below_threshold
);
   import mcv_pkg::*;

   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int N_W    = 2 * COORD_WIDTH + 1;
   localparam int TERM_W = 3 * COORD_WIDTH + 1;
   localparam int T_W    = 3 * COORD_WIDTH + 3;

   // stage a: the six coordinate products
   logic signed [PROD_W-1:0] pa_byaz_ff, pa_bzay_ff, pa_bzax_ff;
   logic signed [PROD_W-1:0] pa_bxaz_ff, pa_bxay_ff, pa_byax_ff;
   logic signed [COORD_WIDTH-1:0] pa_cx_ff, pa_cy_ff, pa_cz_ff;
   logic pa_valid_ff, pa_last_ff;

   // stage b: normal component times third vertex
   logic signed [N_W-1:0]    nx_in, ny_in, nz_in;
   logic signed [TERM_W-1:0] pb_x_ff, pb_y_ff, pb_z_ff;
   logic pb_valid_ff, pb_last_ff;

   // stage c: triple product
   logic signed [T_W-1:0] pc_t_in, pc_t_ff;
   logic pc_valid_ff, pc_last_ff;

   // accumulator
   logic signed [SUM_W-1:0] sum_raw;
   logic signed [ACC_W-1:0] acc_in, acc_ff, acc_neg;
   logic sum_ready_ff;

   // divider and result
   logic [MAG_W-1:0] mag;
   logic [MAG_W-1:0] dvd_ff, quo_ff;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W+1:0] dv_a, dv_b, dv_c;
   logic             qd_hi, qd_lo;
   logic [VOL_W-1:0] thr_ff, volume_ff;
   logic             below_ff;

   always_comb begin
      nx_in = N_W'(pa_byaz_ff) - N_W'(pa_bzay_ff);
      ny_in = N_W'(pa_bzax_ff) - N_W'(pa_bxaz_ff);
      nz_in = N_W'(pa_bxay_ff) - N_W'(pa_byax_ff);
      pc_t_in = T_W'(pb_x_ff) + T_W'(pb_y_ff) + T_W'(pb_z_ff);
   end

   // saturating accumulate
   always_comb begin
      sum_raw = SUM_W'(acc_ff) + SUM_W'(pc_t_ff);
      if (sum_raw > SUM_POS_LIMIT) begin
         acc_in = ACC_W'(SUM_POS_LIMIT);
      end else if (sum_raw < SUM_NEG_LIMIT) begin
         acc_in = ACC_W'(SUM_NEG_LIMIT);
      end else begin
         acc_in = sum_raw[ACC_W-1:0];
      end
   end

   always_comb begin
      acc_neg = -acc_ff;
      mag = acc_ff[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_ff[MAG_W-1:0];
   end

   // two quotient bits per step, remainder stays below six
   always_comb begin
      dv_a  = {rem_ff, dvd_ff[MAG_W-1 -: 2]};
      qd_hi = (dv_a >= DIV_TWELVE);
      dv_b  = qd_hi ? dv_a - DIV_TWELVE : dv_a;
      qd_lo = (dv_b >= DIV_SIX);
      dv_c  = qd_lo ? dv_b - DIV_SIX : dv_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff  <= 1'b0;
         pb_valid_ff  <= 1'b0;
         pc_valid_ff  <= 1'b0;
         sum_ready_ff <= 1'b0;
         acc_ff       <= '0;
         thr_ff       <= '0;
      end else begin
         pa_valid_ff  <= cmd.take;
         pb_valid_ff  <= pa_valid_ff;
         pc_valid_ff  <= pb_valid_ff;
         sum_ready_ff <= pc_valid_ff && pc_last_ff;
         if (cmd.div_start) begin
            acc_ff <= '0;
         end else if (pc_valid_ff) begin
            acc_ff <= acc_in;
         end
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         pa_byaz_ff <= req_second_y * req_first_z;
         pa_bzay_ff <= req_second_z * req_first_y;
         pa_bzax_ff <= req_second_z * req_first_x;
         pa_bxaz_ff <= req_second_x * req_first_z;
         pa_bxay_ff <= req_second_x * req_first_y;
         pa_byax_ff <= req_second_y * req_first_x;
         pa_cx_ff   <= req_third_x;
         pa_cy_ff   <= req_third_y;
         pa_cz_ff   <= req_third_z;
         pa_last_ff <= req_last_triangle;
      end
      pb_x_ff    <= nx_in * pa_cx_ff;
      pb_y_ff    <= ny_in * pa_cy_ff;
      pb_z_ff    <= nz_in * pa_cz_ff;
      pb_last_ff <= pa_last_ff;
      pc_t_ff    <= pc_t_in;
      pc_last_ff <= pb_last_ff;
      if (cmd.div_start) begin
         dvd_ff <= mag;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[MAG_W-3:0], 2'b00};
         quo_ff <= {quo_ff[MAG_W-3:0], qd_hi, qd_lo};
         rem_ff <= dv_c[REM_W-1:0];
      end
      if (cmd.rsp_load) begin
         volume_ff <= quo_ff[VOL_W-1:0];
         below_ff  <= (quo_ff[VOL_W-1:0] < thr_ff);
      end
   end

   assign status.sum_ready    = sum_ready_ff;
   assign rsp_volume          = volume_ff;
   assign rsp_below_threshold = below_ff;

   // the sum never reaches the most negative code
   acc_range_a: assert property (@(posedge clock) disable iff (reset)
      acc_ff != {1'b1, {(ACC_W-1){1'b0}}})
      else $error("running sum outside saturation range");

   acc_clear_a: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (acc_ff == '0))
      else $error("running sum not cleared at divide start");

   quo_fits_a: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (quo_ff[MAG_W-1:VOL_W] == '0))
      else $error("quotient exceeds volume width");

   rem_range_a: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> (rem_ff < DIV_SIX[REM_W-1:0]))
      else $error("divider remainder not below six");

endmodule

@@ rtl/mcv_ctrl.sv @@
module mcv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_last_triangle,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mcv_pkg::mcv_cmd_type    cmd,
   input  mcv_pkg::mcv_status_type status
);
   import mcv_pkg::*;

   typedef enum logic [1:0] {ST_RUN, ST_DRAIN, ST_DIV, ST_LOAD} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;

   assign req_stall = (state_ff != ST_RUN);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.take      = accept;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_last_triangle) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last triangle to land in the sum
            if (status.sum_ready) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_LOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ready_only_a: assert property (@(posedge clock) disable iff (reset)
      status.sum_ready |-> (state_ff == ST_DRAIN))
      else $error("component sum finished outside drain");

   last_stalls_a: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_triangle) |=> req_stall)
      else $error("request taken after a last triangle");

   load_slot_a: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten while stalled");

endmodule

@@ rtl/mesh_component_volume.sv @@
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | three vertices, req_last_triangle
// rsp     | out       | rsp_valid/rsp_stall  | rsp_volume, rsp_below_threshold
// csr     | in        | csr_write_enable     | csr_write_data (volume threshold)
//
// while req_stall is low, a triangle without the last flag is taken every
// cycle; products pass a three stage pipeline into the saturating running sum
// after a last triangle req_stall stays high while the pipeline drains, the
// divider loads, 31 radix-4 divide-by-six steps run and the result loads;
// the result sits in an output register, so new triangles flow while it waits
// reset is synchronous and clears the sum, threshold, pipeline valids and rsp_valid
module mesh_component_volume #(
   parameter int COORD_WIDTH = mcv_pkg::MCV_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   input  logic                          req_last_triangle,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mcv_pkg::VOL_W-1:0]     rsp_volume,
   output logic                          rsp_below_threshold,
   input  logic                          csr_write_enable,
   input  logic [mcv_pkg::VOL_W-1:0]     csr_write_data
);
   import mcv_pkg::*;

   mcv_cmd_type    cmd;
   mcv_status_type status;

   mcv_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_last_triangle (req_last_triangle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .cmd               (cmd),
      .status            (status)
   );

   mcv_datapath #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_first_x         (req_first_x),
      .req_first_y         (req_first_y),
      .req_first_z         (req_first_z),
      .req_second_x        (req_second_x),
      .req_second_y        (req_second_y),
      .req_second_z        (req_second_z),
      .req_third_x         (req_third_x),
      .req_third_y         (req_third_y),
      .req_third_z         (req_third_z),
      .req_last_triangle   (req_last_triangle),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_volume          (rsp_volume),
      .rsp_below_threshold (rsp_below_threshold)
   );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;

   localparam int CW = mcv_pkg::MCV_COORD_WIDTH;
   localparam int VW = mcv_pkg::VOL_W;
   localparam logic [VW-1:0] THRESH_MAX = 60'd768614336404564650;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 48;
   localparam int unsigned CYCLE_LIMIT = 800000;

   typedef struct {
      logic signed [CW-1:0] first_x, first_y, first_z;
      logic signed [CW-1:0] second_x, second_y, second_z;
      logic signed [CW-1:0] third_x, third_y, third_z;
      logic last;
   } facet_type;

   typedef struct {
      logic [VW-1:0] volume;
      logic below;
   } volume_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [CW-1:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic signed [CW-1:0] req_third_x = '0, req_third_y = '0, req_third_z = '0;
   logic req_last_triangle = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [VW-1:0] rsp_volume;
   logic rsp_below_threshold;
   logic csr_write_enable = 1'b0;
   logic [VW-1:0] csr_write_data = '0;

   facet_type facet_q[$];
   volume_report_type volume_expect_q[$];
   facet_type offer;
   longint sum_model = 0;
   logic [VW-1:0] threshold_model = '0;
   int error_count = 0;
   int unsigned cycle_count = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic quiet_tail = 1'b0;
   logic long_hold_req = 1'b0;

   mesh_component_volume u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_x         (req_first_x),
      .req_first_y         (req_first_y),
      .req_first_z         (req_first_z),
      .req_second_x        (req_second_x),
      .req_second_y        (req_second_y),
      .req_second_z        (req_second_z),
      .req_third_x         (req_third_x),
      .req_third_y         (req_third_y),
      .req_third_z         (req_third_z),
      .req_last_triangle   (req_last_triangle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_volume          (rsp_volume),
      .rsp_below_threshold (rsp_below_threshold),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // adds (second x first) . third to the running sum, closes the component on last
   function automatic void accumulate_facet(input facet_type f);
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      longint nx, ny, nz, s;
      longint unsigned mag;
      volume_report_type r;
      ax = f.first_x;  ay = f.first_y;  az = f.first_z;
      bx = f.second_x; by = f.second_y; bz = f.second_z;
      cx = f.third_x;  cy = f.third_y;  cz = f.third_z;
      nx = by * az - bz * ay;
      ny = bz * ax - bx * az;
      nz = bx * ay - by * ax;
      s = sum_model + nx * cx + ny * cy + nz * cz;
      if (s > mcv_pkg::SUM_POS_LIMIT) s = mcv_pkg::SUM_POS_LIMIT;
      if (s < -mcv_pkg::SUM_POS_LIMIT) s = -mcv_pkg::SUM_POS_LIMIT;
      sum_model = s;
      if (f.last) begin
         mag = (s < 0) ? longint'(-s) : longint'(s);
         r.volume = VW'(mag / 6);
         r.below = (r.volume < threshold_model);
         volume_expect_q.insert(volume_expect_q.size(), r);
         sum_model = 0;
      end
   endfunction

   task automatic flag_mismatch(input string what, input longint unsigned got,
                                input longint unsigned want);
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      case ($urandom_range(7))
         0: return {1'b1, {(CW-1){1'b0}}};
         1: return {1'b0, {(CW-1){1'b1}}};
         2, 3: return CW'($urandom_range(1023) - 512);
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic void push_facet(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                      input logic last);
      facet_type f;
      f.first_x = CW'(ax);  f.first_y = CW'(ay);  f.first_z = CW'(az);
      f.second_x = CW'(bx); f.second_y = CW'(by); f.second_z = CW'(bz);
      f.third_x = CW'(cx);  f.third_y = CW'(cy);  f.third_z = CW'(cz);
      f.last = last;
      facet_q.insert(facet_q.size(), f);
   endfunction

   // short components with random vertices, returns the number of triangles queued
   function automatic int push_component(input int max_len);
      int n;
      n = ($urandom_range(3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if (n > max_len) n = $urandom_range(1, max_len);
      for (int i = 0; i < n; i++) begin
         push_facet(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == n - 1);
      end
      return n;
   endfunction

   // near-maximal triple product, sign picked by the vertex order
   function automatic void push_big_run(input int n, input logic positive, input logic last);
      for (int i = 0; i < n; i++) begin
         if (positive)
            push_facet(-32768, -32768, -32768, -32768, 32767, -32768,
                       -32768, -32768, 32767, last && i == n - 1);
         else
            push_facet(-32768, 32767, -32768, -32768, -32768, -32768,
                       -32768, -32768, 32767, last && i == n - 1);
      end
   endfunction

   task automatic set_threshold(input logic [VW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      threshold_model = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain_phase();
      while (facet_q.size() != 0 || req_valid || volume_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic random_threshold();
      logic [63:0] w;
      w = {$urandom, $urandom};
      set_threshold(VW'(w >> $urandom_range(18, 40)));
   endtask

   // driver
   always @(posedge clock) begin
      logic take_next;
      logic valid_next;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         take_next = !req_valid;
         if (req_valid && !req_stall) begin
            accumulate_facet(offer);
            take_next = 1'b1;
            if (!quiet_tail && $urandom_range(7) == 0)
               send_gap = $urandom_range(1, 19);
         end
         valid_next = req_valid && !take_next;
         if (take_next) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (facet_q.size() != 0) begin
               offer = facet_q.pop_front();
               valid_next = 1'b1;
               req_first_x <= offer.first_x;
               req_first_y <= offer.first_y;
               req_first_z <= offer.first_z;
               req_second_x <= offer.second_x;
               req_second_y <= offer.second_y;
               req_second_z <= offer.second_z;
               req_third_x <= offer.third_x;
               req_third_y <= offer.third_y;
               req_third_z <= offer.third_z;
               req_last_triangle <= offer.last;
            end
         end
         req_valid <= valid_next;
      end
   end

   // long receiver hold, counted down one cycle at a time
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (long_hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and result-side stall
   always @(posedge clock) begin
      volume_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (volume_expect_q.size() == 0) begin
               flag_mismatch("unexpected result volume", 64'(rsp_volume), 64'd0);
            end else begin
               want = volume_expect_q.pop_front();
               if (rsp_volume !== want.volume)
                  flag_mismatch("volume", 64'(rsp_volume), 64'(want.volume));
               if (rsp_below_threshold !== want.below)
                  flag_mismatch("below_threshold", 64'(rsp_below_threshold),
                                64'(want.below));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(7) == 0) begin
            recv_gap = $urandom_range(1, 19) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   initial begin
      int queued;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // threshold still at its reset value
      push_facet(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
      push_facet(256, 0, 0, 0, 256, 0, 0, 0, 256, 1'b1);
      push_facet(0, 256, 0, 256, 0, 0, 0, 0, 256, 1'b1);
      // tiny sums, division truncates toward zero
      push_facet(1, 0, 0, 0, 1, 0, 0, 0, -7, 1'b1);
      push_facet(0, 1, 0, 1, 0, 0, 0, 0, -5, 1'b1);
      // two triangles that cancel
      push_facet(300, -20, 7, -45, 900, 12, 3, 3, -1000, 1'b0);
      push_facet(-45, 900, 12, 300, -20, 7, 3, 3, -1000, 1'b1);
      push_big_run(1, 1'b1, 1'b1);
      push_big_run(1, 1'b0, 1'b1);
      push_facet(-32768, -32768, -32768, -32768, -32768, -32768,
                 -32768, -32768, -32768, 1'b1);
      push_facet(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1);
      push_facet(32767, -32768, 32767, -32768, 32767, 32767, 32767, 32767, -32768, 1'b0);
      push_facet(-32768, 32767, -32768, 32767, -32768, -32768, 1, -1, 0, 1'b0);
      push_facet(-1, -1, -1, 32767, -32768, 1, -32768, 255, 256, 1'b0);
      push_facet(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
      drain_phase();

      // volume equal to the threshold is not below it
      set_threshold(60'd2796202);
      push_facet(0, 256, 0, 256, 0, 0, 0, 0, 256, 1'b1);
      push_facet(256, 0, 0, 0, 256, 0, 0, 0, 256, 1'b1);
      drain_phase();
      set_threshold(60'd2796203);
      push_facet(0, 256, 0, 256, 0, 0, 0, 0, 256, 1'b1);
      drain_phase();

      set_threshold(THRESH_MAX);
      queued = 0;
      while (queued < 150) queued += push_component(40);
      drain_phase();

      // long receiver hold while short components keep arriving
      random_threshold();
      long_hold_req = 1'b1;
      queued = 0;
      while (queued < 170) queued += push_component(3);
      drain_phase();

      random_threshold();
      quiet_tail = 1'b1;
      queued = 0;
      while (queued < 180) queued += push_component(40);
      drain_phase();

      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
